// File: hw/rtl/lrs_pkg.sv
// shared types and constants for the link retry supervisor
package lrs_pkg;

   localparam int unsigned CountWidth = 8;
   localparam int unsigned CsrDataWidth = 8;
   localparam int unsigned CsrIndexWidth = 1;

   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
   localparam logic [CsrDataWidth-1:0] AttemptsReset = 8'd3;
   localparam logic [CsrDataWidth-1:0] SelfLeaveReset = 8'd8;
   localparam logic [7:0] ReasonNone = 8'd0;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ATTEMPTS   = 1'b0,
      CSR_SELF_LEAVE = 1'b1
   } lrs_csr_index_type;

   typedef enum logic [2:0] {
      MODE_TICK      = 3'd0,
      MODE_LINK_UP   = 3'd1,
      MODE_LINK_DOWN = 3'd2,
      MODE_GOT_ADDR  = 3'd3,
      MODE_LOST_ADDR = 3'd4,
      MODE_START     = 3'd5
   } lrs_mode_type;

   typedef enum logic [1:0] {
      RADIO_NONE      = 2'd0,
      RADIO_JOIN      = 2'd1,
      RADIO_RECONNECT = 2'd2,
      RADIO_START_AP  = 2'd3
   } lrs_radio_type;

   typedef enum logic [2:0] {
      TIMER_NONE      = 3'd0,
      TIMER_CONNECT   = 3'd1,
      TIMER_ADDR_WAIT = 3'd2,
      TIMER_RETRY     = 3'd3,
      TIMER_AP_WINDOW = 3'd4,
      TIMER_PROV_POLL = 3'd5,
      TIMER_STOP      = 3'd6
   } lrs_timer_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] reason;
      logic       radio_in_ap;
      logic       credentials_present;
   } lrs_req_type;

   typedef struct packed {
      logic [1:0]            radio_action;
      logic [2:0]            timer_action;
      logic                  link_connected;
      logic                  window_open;
      logic [CountWidth-1:0] attempts_now;
   } lrs_rsp_type;

   typedef struct packed {
      logic                  ap_window;
      logic                  connected;
      logic                  associated;
      logic [CountWidth-1:0] round_count;
   } lrs_state_type;

   typedef struct packed {
      logic [CsrDataWidth-1:0] attempts_per_round;
      logic [CsrDataWidth-1:0] self_leave_reason;
   } lrs_cfg_type;

endpackage

// File: hw/rtl/lrs_csr.sv
// configuration registers of the link retry supervisor
module lrs_csr
   import lrs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output lrs_cfg_type              cfg
);

   lrs_cfg_type cfg_ff;
   lrs_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (lrs_csr_index_type'(csr_index))
            CSR_ATTEMPTS:   cfg_in.attempts_per_round = csr_wdata;
            CSR_SELF_LEAVE: cfg_in.self_leave_reason = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attempts_per_round <= AttemptsReset;
         cfg_ff.self_leave_reason <= SelfLeaveReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/lrs_decide.sv
// event decision logic: next link state and radio and timer commands
module lrs_decide
   import lrs_pkg::*;
(
   input  lrs_req_type   req,
   input  lrs_state_type state,
   input  lrs_cfg_type   cfg,
   output lrs_state_type state_next,
   output lrs_rsp_type   rsp
);

   lrs_state_type         nxt;
   lrs_radio_type         radio;
   lrs_timer_type         timer;
   logic [CountWidth-1:0] cnt_inc;
   logic                  do_begin;
   logic                  do_count;
   logic                  do_try;
   logic                  do_prov;
   logic                  fresh;

   always_comb begin
      nxt = state;
      radio = RADIO_NONE;
      timer = TIMER_NONE;
      do_begin = 1'b0;
      do_count = 1'b0;
      do_try = 1'b0;
      do_prov = 1'b0;
      fresh = 1'b0;
      cnt_inc = (state.round_count == CountMax) ? state.round_count
                                                 : state.round_count + 1'b1;

      unique case (req.mode)
         MODE_TICK: begin
            if (state.ap_window) begin
               do_begin = 1'b1;
            end else if (!state.connected) begin
               nxt.associated = 1'b0;
               do_count = 1'b1;
               fresh = state.associated;
            end
         end
         MODE_LINK_UP: begin
            if (!req.radio_in_ap) begin
               nxt.associated = 1'b1;
               timer = TIMER_ADDR_WAIT;
            end
         end
         MODE_LINK_DOWN: begin
            if (!(req.radio_in_ap || state.ap_window)) begin
               if (state.connected) begin
                  nxt.connected = 1'b0;
                  nxt.associated = 1'b0;
                  nxt.round_count = '0;
                  radio = RADIO_RECONNECT;
                  timer = TIMER_CONNECT;
               end else if (!(req.reason == ReasonNone ||
                              req.reason == cfg.self_leave_reason)) begin
                  nxt.associated = 1'b0;
                  timer = TIMER_RETRY;
               end
            end
         end
         MODE_GOT_ADDR: begin
            timer = TIMER_STOP;
            nxt.ap_window = 1'b0;
            nxt.connected = 1'b1;
            nxt.associated = 1'b0;
            nxt.round_count = '0;
         end
         MODE_LOST_ADDR: begin
            nxt.connected = 1'b0;
            nxt.associated = 1'b1;
            timer = TIMER_ADDR_WAIT;
         end
         MODE_START: do_begin = 1'b1;
         default: nxt = state;
      endcase

      // new round
      if (do_begin) begin
         if (req.credentials_present) begin
            nxt.round_count = '0;
            do_try = 1'b1;
            fresh = 1'b1;
         end else begin
            do_prov = 1'b1;
         end
      end

      // failed attempt
      if (do_count) begin
         nxt.round_count = cnt_inc;
         if (cnt_inc >= cfg.attempts_per_round) begin
            nxt.ap_window = 1'b1;
            radio = RADIO_START_AP;
            timer = TIMER_AP_WINDOW;
         end else begin
            do_try = 1'b1;
         end
      end

      if (do_try) begin
         if (req.credentials_present) begin
            nxt.ap_window = 1'b0;
            nxt.connected = 1'b0;
            nxt.associated = 1'b0;
            radio = fresh ? RADIO_JOIN : RADIO_RECONNECT;
            timer = TIMER_CONNECT;
         end else begin
            do_prov = 1'b1;
         end
      end

      // provisioning access point
      if (do_prov) begin
         nxt.ap_window = 1'b1;
         radio = req.radio_in_ap ? RADIO_NONE : RADIO_START_AP;
         timer = TIMER_PROV_POLL;
      end
   end

   assign state_next = nxt;
   assign rsp.radio_action = radio;
   assign rsp.timer_action = timer;
   assign rsp.link_connected = nxt.connected;
   assign rsp.window_open = nxt.ap_window;
   assign rsp.attempts_now = nxt.round_count;

endmodule

// File: hw/rtl/link_retry_supervisor.sv
// link retry supervisor top level: request register, decision logic, response register
// a request goes from the request register into the response register on rsp_load
// throughput: one request per cycle unless the response stalls; no link state hazard
// while a response waits, the request register takes one more request, then stalls
// reset clears all link state and valid flags and loads the configuration defaults
module link_retry_supervisor
   import lrs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lrs_req_type              req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lrs_rsp_type              rsp_data,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   lrs_req_type   req_ff;
   logic          req_valid_ff;
   logic          req_valid_in;
   lrs_rsp_type   rsp_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   lrs_state_type state_ff;
   lrs_state_type state_in;
   lrs_rsp_type   rsp_in;
   lrs_cfg_type   cfg;
   logic          rsp_load;
   logic          fire;
   logic          req_take;

   lrs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lrs_decide u_decide (
      .req        (req_ff),
      .state      (state_ff),
      .cfg        (cfg),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   assign rsp_load = !rsp_valid_ff || !rsp_stall;
   assign fire = req_valid_ff && rsp_load;
   assign req_stall = req_valid_ff && !rsp_load;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (fire) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // link state moves only with a request that reaches the response register
   assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(state_ff))
      else $error("link state changed without a request");

   // flags in the response match the committed state
   assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_ff.window_open == state_ff.ap_window &&
                rsp_ff.link_connected == state_ff.connected &&
                rsp_ff.attempts_now == state_ff.round_count))
      else $error("response flags differ from link state");

   // starting the own access point always arms a window or provisioning timer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.radio_action == RADIO_START_AP |->
         (rsp_ff.timer_action == TIMER_AP_WINDOW || rsp_ff.timer_action == TIMER_PROV_POLL))
      else $error("access point start without its timer");

   // arming the provisioning timer always leaves the window flag set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.timer_action == TIMER_PROV_POLL |-> rsp_ff.window_open)
      else $error("provisioning without window flag");

   // link state is clear right after reset
   assert property (@(posedge clock)
      $past(reset) |-> state_ff == '0)
      else $error("link state not cleared by reset");

endmodule

// File: verif/testbench.sv
// testbench for the link retry supervisor: link event requests, a state predictor and response checks
import lrs_pkg::*;

class link_event_scoreboard;
   logic [CsrDataWidth-1:0] attempts_per_round;
   logic [CsrDataWidth-1:0] self_leave_reason;
   logic                    window;
   logic                    connected;
   logic                    associated;
   logic [CountWidth-1:0]   round_count;
   lrs_radio_type           next_radio;
   lrs_timer_type           next_timer;
   lrs_rsp_type             expected_q[$];
   int                      mismatches;
   int                      checked;

   function new();
      attempts_per_round = AttemptsReset;
      self_leave_reason = SelfLeaveReset;
      window = 1'b0;
      connected = 1'b0;
      associated = 1'b0;
      round_count = '0;
      mismatches = 0;
      checked = 0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void open_provisioning(logic in_ap);
      window = 1'b1;
      if (!in_ap) begin
         next_radio = RADIO_START_AP;
      end
      next_timer = TIMER_PROV_POLL;
   endfunction

   function void join_station(logic fresh, lrs_req_type r);
      if (!r.credentials_present) begin
         open_provisioning(r.radio_in_ap);
      end else begin
         window = 1'b0;
         connected = 1'b0;
         associated = 1'b0;
         next_radio = fresh ? RADIO_JOIN : RADIO_RECONNECT;
         next_timer = TIMER_CONNECT;
      end
   endfunction

   function void new_round(lrs_req_type r);
      if (!r.credentials_present) begin
         open_provisioning(r.radio_in_ap);
      end else begin
         round_count = '0;
         join_station(1'b1, r);
      end
   endfunction

   function void failed_attempt(logic fresh, lrs_req_type r);
      if (round_count != CountMax) begin
         round_count = round_count + 1'b1;
      end
      if (round_count >= attempts_per_round) begin
         window = 1'b1;
         next_radio = RADIO_START_AP;
         next_timer = TIMER_AP_WINDOW;
      end else begin
         join_station(fresh, r);
      end
   endfunction

   function void note_request(lrs_req_type r);
      lrs_rsp_type exp_rsp;
      logic        was_associated;
      next_radio = RADIO_NONE;
      next_timer = TIMER_NONE;
      case (r.mode)
         MODE_TICK: begin
            if (window) begin
               new_round(r);
            end else if (!connected) begin
               was_associated = associated;
               associated = 1'b0;
               failed_attempt(was_associated, r);
            end
         end
         MODE_LINK_UP: begin
            if (!r.radio_in_ap) begin
               associated = 1'b1;
               next_timer = TIMER_ADDR_WAIT;
            end
         end
         MODE_LINK_DOWN: begin
            if (!r.radio_in_ap && !window) begin
               if (connected) begin
                  connected = 1'b0;
                  associated = 1'b0;
                  round_count = '0;
                  next_radio = RADIO_RECONNECT;
                  next_timer = TIMER_CONNECT;
               end else if (r.reason != ReasonNone && r.reason != self_leave_reason) begin
                  associated = 1'b0;
                  next_timer = TIMER_RETRY;
               end
            end
         end
         MODE_GOT_ADDR: begin
            next_timer = TIMER_STOP;
            window = 1'b0;
            connected = 1'b1;
            associated = 1'b0;
            round_count = '0;
         end
         MODE_LOST_ADDR: begin
            connected = 1'b0;
            associated = 1'b1;
            next_timer = TIMER_ADDR_WAIT;
         end
         MODE_START: begin
            new_round(r);
         end
         default: begin
         end
      endcase
      exp_rsp.radio_action = next_radio;
      exp_rsp.timer_action = next_timer;
      exp_rsp.link_connected = connected;
      exp_rsp.window_open = window;
      exp_rsp.attempts_now = round_count;
      expected_q.push_back(exp_rsp);
   endfunction

   task report(string what, int got_val, int want_val);
      mismatches++;
      if (mismatches <= 100) begin
         $display("mismatch at response %0d: %s got %0d expected %0d",
                  checked, what, got_val, want_val);
      end
   endtask

   task check_response(lrs_rsp_type got);
      lrs_rsp_type want;
      if (expected_q.size() == 0) begin
         report("response with no request outstanding", 0, 0);
      end else begin
         want = expected_q.pop_front();
         if (got.radio_action !== want.radio_action) begin
            report("radio_action", got.radio_action, want.radio_action);
         end
         if (got.timer_action !== want.timer_action) begin
            report("timer_action", got.timer_action, want.timer_action);
         end
         if (got.link_connected !== want.link_connected) begin
            report("link_connected", got.link_connected, want.link_connected);
         end
         if (got.window_open !== want.window_open) begin
            report("window_open", got.window_open, want.window_open);
         end
         if (got.attempts_now !== want.attempts_now) begin
            report("attempts_now", got.attempts_now, want.attempts_now);
         end
      end
      checked++;
   endtask
endclass

module testbench;
   localparam int QuietLimit = 2000;
   localparam int PhaseItems = 200;
   localparam int PhaseCount = 8;
   localparam int TickPct = 40;
   localparam int LongRunTicks = 260;
   localparam logic [2:0] ModeUnusedLow = 3'd6;
   localparam logic [2:0] ModeUnusedHigh = 3'd7;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   lrs_req_type              req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   lrs_rsp_type              rsp_data;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   int                   send_idle_pct = 0;
   int                   rsp_stall_pct = 0;
   int                   quiet_cycles = 0;
   link_event_scoreboard link_sb;

   int attempts_tab [PhaseCount] = '{3, 1, 255, 0, 2, 6, 17, 3};
   int leave_tab [PhaseCount] = '{8, 0, 255, 1, 8, 44, 200, 8};

   link_retry_supervisor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         link_sb.check_response(rsp_data);
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic lrs_req_type request_of(logic [2:0] mode, logic [7:0] reason,
                                               logic in_ap, logic cred);
      lrs_req_type r;
      r.mode = mode;
      r.reason = reason;
      r.radio_in_ap = in_ap;
      r.credentials_present = cred;
      return r;
   endfunction

   function automatic lrs_req_type random_request(int tick_pct);
      lrs_req_type r;
      int          pick;
      pick = $urandom_range(99);
      if (pick < tick_pct) begin
         r.mode = MODE_TICK;
      end else if (pick < 96) begin
         r.mode = 3'($urandom_range(MODE_LINK_UP, MODE_START));
      end else begin
         r.mode = 3'($urandom_range(MODE_TICK, ModeUnusedHigh));
      end
      case ($urandom_range(3))
         0: r.reason = ReasonNone;
         1: r.reason = link_sb.self_leave_reason;
         default: r.reason = 8'($urandom);
      endcase
      r.radio_in_ap = ($urandom_range(99) < 20);
      r.credentials_present = ($urandom_range(99) < 85);
      return r;
   endfunction

   task automatic send_request(input lrs_req_type r);
      logic taken;
      taken = 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
         if (taken) begin
            link_sb.note_request(r);
         end
         @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      while (link_sb.pending() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_csr(input lrs_csr_index_type idx, input logic [CsrDataWidth-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_ATTEMPTS) begin
         link_sb.attempts_per_round = value;
      end else begin
         link_sb.self_leave_reason = value;
      end
      @(negedge clock);
   endtask

   initial begin
      link_sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_ATTEMPTS;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // provisioning paths, a full round to the ap window, then the connected paths
      send_request(request_of(MODE_START, 8'h00, 1'b0, 1'b0));
      send_request(request_of(MODE_START, 8'hff, 1'b1, 1'b0));
      send_request(request_of(MODE_TICK, 8'h55, 1'b0, 1'b0));
      send_request(request_of(MODE_START, 8'haa, 1'b0, 1'b1));
      send_request(request_of(MODE_TICK, 8'hff, 1'b1, 1'b1));
      send_request(request_of(MODE_LINK_UP, 8'h00, 1'b0, 1'b1));
      send_request(request_of(MODE_TICK, 8'h01, 1'b0, 1'b1));
      send_request(request_of(MODE_LINK_DOWN, ReasonNone, 1'b0, 1'b1));
      send_request(request_of(MODE_LINK_DOWN, SelfLeaveReset, 1'b0, 1'b1));
      send_request(request_of(MODE_LINK_DOWN, 8'hff, 1'b0, 1'b1));
      send_request(request_of(MODE_LINK_UP, 8'h80, 1'b1, 1'b1));
      send_request(request_of(MODE_TICK, 8'h00, 1'b0, 1'b1));
      send_request(request_of(MODE_LINK_DOWN, 8'h05, 1'b0, 1'b1));
      send_request(request_of(MODE_TICK, 8'h00, 1'b1, 1'b1));
      send_request(request_of(MODE_GOT_ADDR, 8'h00, 1'b0, 1'b1));
      send_request(request_of(MODE_TICK, 8'h00, 1'b0, 1'b1));
      send_request(request_of(MODE_LINK_DOWN, ReasonNone, 1'b0, 1'b1));
      send_request(request_of(MODE_LOST_ADDR, 8'h7f, 1'b0, 1'b0));
      send_request(request_of(ModeUnusedLow, 8'hff, 1'b1, 1'b1));
      send_request(request_of(ModeUnusedHigh, 8'h00, 1'b0, 1'b0));
      send_request(request_of(MODE_LINK_DOWN, 8'h03, 1'b1, 1'b1));
      send_request(request_of(MODE_GOT_ADDR, 8'hff, 1'b1, 1'b0));

      for (int p = 0; p < PhaseCount; p++) begin
         req_valid <= 1'b0;
         wait_drained();
         if (p != 0) begin
            write_csr(CSR_ATTEMPTS, 8'(attempts_tab[p]));
            write_csr(CSR_SELF_LEAVE, 8'(leave_tab[p]));
         end
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 55;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 55;
            end
            default: begin
               send_idle_pct = 14;
               rsp_stall_pct = 14;
            end
         endcase
         // long run of failed attempts walks the count up to the largest round size
         if (attempts_tab[p] == CountMax) begin
            send_request(request_of(MODE_START, 8'($urandom), 1'($urandom), 1'b1));
            for (int i = 0; i < LongRunTicks; i++) begin
               send_request(request_of(MODE_TICK, 8'($urandom), 1'($urandom), 1'b1));
            end
         end
         for (int i = 0; i < PhaseItems; i++) begin
            send_request(random_request(TickPct));
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      if (link_sb.mismatches == 0 && link_sb.pending() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
